// File: design/iat_pkg.sv
package iat_pkg;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PRE_SUB,
        S_TMR_CMP,
        S_TMR_DEC,
        S_DONE
    } t_state;

    localparam logic [3:0] ADDR_PRA  = 4'd0;
    localparam logic [3:0] ADDR_PRB  = 4'd1;
    localparam logic [3:0] ADDR_DDRA = 4'd2;
    localparam logic [3:0] ADDR_DDRB = 4'd3;
    localparam logic [3:0] ADDR_TALO = 4'd4;
    localparam logic [3:0] ADDR_TAHI = 4'd5;
    localparam logic [3:0] ADDR_TBLO = 4'd6;
    localparam logic [3:0] ADDR_TBHI = 4'd7;
    localparam logic [3:0] ADDR_TODL = 4'd8;
    localparam logic [3:0] ADDR_TODM = 4'd9;
    localparam logic [3:0] ADDR_TODH = 4'd10;
    localparam logic [3:0] ADDR_SDR  = 4'd12;
    localparam logic [3:0] ADDR_ICR  = 4'd13;
    localparam logic [3:0] ADDR_CRA  = 4'd14;
    localparam logic [3:0] ADDR_CRB  = 4'd15;

    localparam int CR_START   = 0;
    localparam int CR_ONESHOT = 3;
    localparam int CR_LOAD    = 4;
    localparam int FLAG_IR    = 7;

    // Operand and result of the shared add/subtract unit.
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic        sub;
    } t_alu_req;

    typedef struct packed {
        logic [15:0] sum;
        logic        carry;
    } t_alu_rsp;

endpackage

// File: design/interface_adapter_timers_ports_core.sv
// Interface adapter core with two 8-bit ports, two 16-bit interval timers, a
// 24-bit time-of-day counter, a serial data register and an interrupt control
// register. Each input transaction carries a command in tuser (read, write or
// a timer tick, or none) and returns exactly one output transaction with the read
// byte and an interrupt pulse flag. A read or write passes through the EXEC and
// DONE states and presents its result in the output register when DONE returns
// to IDLE. A tick goes through one shared add/subtract unit: the EXEC and
// PRE_SUB states update the TOD prescaler, then each timer steps through
// TMR_CMP once per underflow plus a closing pass, with a TMR_DEC and a further
// TMR_CMP when the timer ends on a partial count. The input is not ready while
// an item is in progress, and DONE holds while the output register is full;
// the output register lets the next item be accepted while a result waits.
module interface_adapter_timers_ports_core #(
    parameter int TOD_DIVIDE = 1419
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // reg_addr[3:0], write_data[11:4], tick_count[19:12], port_a_pins[27:20],
    // port_b_pins[35:28], zero fill above.
    input  logic [39:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_data[7:0]
    output logic [7:0]  o_m_axis_tdata,
    // irq_pulse[0]
    output logic        o_m_axis_tuser
);
    localparam logic [15:0] TodDiv = 16'(TOD_DIVIDE);

    iat_pkg::t_state r_state, n_state;

    logic [1:0]  r_cmd, n_cmd;
    logic [3:0]  r_addr, n_addr;
    logic [7:0]  r_wdata, n_wdata, r_clocks, n_clocks, r_pa, n_pa, r_pb, n_pb;

    logic [7:0]  r_pra, n_pra, r_prb, n_prb, r_ddra, n_ddra, r_ddrb, n_ddrb;
    logic [15:0] r_ta_rel, n_ta_rel, r_tb_rel, n_tb_rel;
    logic [15:0] r_ta_cnt, n_ta_cnt, r_tb_cnt, n_tb_cnt;
    logic [7:0]  r_cra, n_cra, r_crb, n_crb;
    logic [23:0] r_tod, n_tod, r_tod_hold, n_tod_hold;
    logic        r_hold_vld, n_hold_vld;
    logic [10:0] r_presc, n_presc;
    logic [7:0]  r_sdr, n_sdr, r_flags, n_flags;
    logic [6:0]  r_ien, n_ien;

    logic [11:0] r_acc, n_acc;
    logic [7:0]  r_left, n_left;
    logic        r_sel, n_sel;
    logic [7:0]  r_rd, n_rd;
    logic        r_pulse, n_pulse;

    logic        r_m_valid, n_m_valid;
    logic [7:0]  r_m_data, n_m_data;
    logic        r_m_user, n_m_user;

    iat_pkg::t_alu_req w_req;
    iat_pkg::t_alu_rsp w_rsp;

    logic [15:0] w_cnt, w_rel;
    logic [7:0]  w_cr;
    logic [1:0]  w_bit;
    logic [23:0] w_tod_view;
    logic [11:0] w_pre_val;
    logic [6:0]  w_ien_new;

    iat_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_cnt = r_sel ? r_tb_cnt : r_ta_cnt;
    assign w_rel = r_sel ? r_tb_rel : r_ta_rel;
    assign w_cr  = r_sel ? r_crb : r_cra;
    assign w_bit = r_sel ? 2'b10 : 2'b01;
    assign w_tod_view = r_hold_vld ? r_tod_hold : r_tod;

    always_comb begin
        w_req = '0;
        case (r_state)
            iat_pkg::S_EXEC: begin
                w_req.a = {5'd0, r_presc};
                w_req.b = {8'd0, r_clocks};
            end
            iat_pkg::S_PRE_SUB: begin
                w_req.a   = {4'd0, r_acc};
                w_req.b   = TodDiv;
                w_req.sub = 1'b1;
            end
            iat_pkg::S_TMR_CMP: begin
                w_req.a   = {8'd0, r_left};
                w_req.b   = w_cnt;
                w_req.sub = 1'b1;
            end
            iat_pkg::S_TMR_DEC: begin
                w_req.a   = w_cnt;
                w_req.b   = {8'd0, r_left};
                w_req.sub = 1'b1;
            end
            default: w_req = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cmd = r_cmd; n_addr = r_addr; n_wdata = r_wdata; n_clocks = r_clocks;
        n_pa = r_pa; n_pb = r_pb;
        n_pra = r_pra; n_prb = r_prb; n_ddra = r_ddra; n_ddrb = r_ddrb;
        n_ta_rel = r_ta_rel; n_tb_rel = r_tb_rel; n_ta_cnt = r_ta_cnt; n_tb_cnt = r_tb_cnt;
        n_cra = r_cra; n_crb = r_crb; n_tod = r_tod; n_tod_hold = r_tod_hold;
        n_hold_vld = r_hold_vld; n_presc = r_presc; n_sdr = r_sdr;
        n_flags = r_flags; n_ien = r_ien;
        n_acc = r_acc; n_left = r_left; n_sel = r_sel; n_rd = r_rd; n_pulse = r_pulse;
        n_m_valid = r_m_valid; n_m_data = r_m_data; n_m_user = r_m_user;
        w_pre_val = '0;
        w_ien_new = '0;
        o_s_axis_tready = (r_state == iat_pkg::S_IDLE);

        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            iat_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_cmd    = i_s_axis_tuser;
                    n_addr   = i_s_axis_tdata[3:0];
                    n_wdata  = i_s_axis_tdata[11:4];
                    n_clocks = i_s_axis_tdata[19:12];
                    n_pa     = i_s_axis_tdata[27:20];
                    n_pb     = i_s_axis_tdata[35:28];
                    n_state  = iat_pkg::S_EXEC;
                end
            end
            iat_pkg::S_EXEC: begin
                n_rd    = '0;
                n_pulse = 1'b0;
                n_state = iat_pkg::S_DONE;
                case (r_cmd)
                    iat_pkg::CMD_READ: begin
                        case (r_addr)
                            iat_pkg::ADDR_PRA:  n_rd = (r_pra & r_ddra) | (r_pa & ~r_ddra);
                            iat_pkg::ADDR_PRB:  n_rd = (r_prb & r_ddrb) | (r_pb & ~r_ddrb);
                            iat_pkg::ADDR_DDRA: n_rd = r_ddra;
                            iat_pkg::ADDR_DDRB: n_rd = r_ddrb;
                            iat_pkg::ADDR_TALO: n_rd = r_ta_cnt[7:0];
                            iat_pkg::ADDR_TAHI: n_rd = r_ta_cnt[15:8];
                            iat_pkg::ADDR_TBLO: n_rd = r_tb_cnt[7:0];
                            iat_pkg::ADDR_TBHI: n_rd = r_tb_cnt[15:8];
                            iat_pkg::ADDR_TODL: begin
                                n_rd       = w_tod_view[7:0];
                                n_hold_vld = 1'b0;
                            end
                            iat_pkg::ADDR_TODM: n_rd = w_tod_view[15:8];
                            iat_pkg::ADDR_TODH: begin
                                n_rd       = r_tod[23:16];
                                n_tod_hold = r_tod;
                                n_hold_vld = 1'b1;
                            end
                            iat_pkg::ADDR_SDR:  n_rd = r_sdr;
                            iat_pkg::ADDR_ICR: begin
                                n_rd    = r_flags;
                                n_flags = '0;
                            end
                            iat_pkg::ADDR_CRA:  n_rd = r_cra;
                            iat_pkg::ADDR_CRB:  n_rd = r_crb;
                            default:            n_rd = 8'hFF;
                        endcase
                    end
                    iat_pkg::CMD_WRITE: begin
                        case (r_addr)
                            iat_pkg::ADDR_PRA:  n_pra = r_wdata;
                            iat_pkg::ADDR_PRB:  n_prb = r_wdata;
                            iat_pkg::ADDR_DDRA: n_ddra = r_wdata;
                            iat_pkg::ADDR_DDRB: n_ddrb = r_wdata;
                            iat_pkg::ADDR_TALO: n_ta_rel = {r_ta_rel[15:8], r_wdata};
                            iat_pkg::ADDR_TAHI: begin
                                n_ta_rel = {r_wdata, r_ta_rel[7:0]};
                                if (!r_cra[iat_pkg::CR_START]) n_ta_cnt = n_ta_rel;
                            end
                            iat_pkg::ADDR_TBLO: n_tb_rel = {r_tb_rel[15:8], r_wdata};
                            iat_pkg::ADDR_TBHI: begin
                                n_tb_rel = {r_wdata, r_tb_rel[7:0]};
                                if (!r_crb[iat_pkg::CR_START]) n_tb_cnt = n_tb_rel;
                            end
                            iat_pkg::ADDR_TODL: n_tod = {r_tod[23:8], r_wdata};
                            iat_pkg::ADDR_TODM: n_tod = {r_tod[23:16], r_wdata, r_tod[7:0]};
                            iat_pkg::ADDR_TODH: n_tod = {r_wdata, r_tod[15:0]};
                            iat_pkg::ADDR_SDR:  n_sdr = r_wdata;
                            iat_pkg::ADDR_ICR: begin
                                if (r_wdata[7]) w_ien_new = r_ien | r_wdata[6:0];
                                else            w_ien_new = r_ien & ~r_wdata[6:0];
                                n_ien = w_ien_new;
                                if (((r_flags[4:0] & w_ien_new[4:0]) != 5'd0)
                                    && !r_flags[iat_pkg::FLAG_IR]) begin
                                    n_flags[iat_pkg::FLAG_IR] = 1'b1;
                                    n_pulse                   = 1'b1;
                                end
                            end
                            iat_pkg::ADDR_CRA: begin
                                if (r_wdata[iat_pkg::CR_LOAD]) n_ta_cnt = r_ta_rel;
                                n_cra = r_wdata;
                                n_cra[iat_pkg::CR_LOAD] = 1'b0;
                            end
                            iat_pkg::ADDR_CRB: begin
                                if (r_wdata[iat_pkg::CR_LOAD]) n_tb_cnt = r_tb_rel;
                                n_crb = r_wdata;
                                n_crb[iat_pkg::CR_LOAD] = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                    iat_pkg::CMD_TICK: begin
                        n_acc   = w_rsp.sum[11:0];
                        n_state = iat_pkg::S_PRE_SUB;
                    end
                    default: ;
                endcase
            end
            iat_pkg::S_PRE_SUB: begin
                if (w_rsp.carry) begin
                    w_pre_val = w_rsp.sum[11:0];
                    n_tod     = r_tod + 24'd1;
                end else begin
                    w_pre_val = r_acc;
                end
                n_presc = w_pre_val[11] ? 11'h7FF : w_pre_val[10:0];
                n_sel   = 1'b0;
                n_left  = r_clocks;
                n_state = iat_pkg::S_TMR_CMP;
            end
            iat_pkg::S_TMR_CMP: begin
                if (!w_cr[iat_pkg::CR_START] || (w_rel == 16'd0) || (r_left == 8'd0)) begin
                    n_left = r_clocks;
                    n_sel  = 1'b1;
                    if (r_sel) n_state = iat_pkg::S_DONE;
                end else if (w_rsp.carry) begin
                    n_left = w_rsp.sum[7:0];
                    n_flags[1:0] = r_flags[1:0] | w_bit;
                    if ((r_ien[1:0] & w_bit) != 2'd0) begin
                        n_flags[iat_pkg::FLAG_IR] = 1'b1;
                        n_pulse                   = 1'b1;
                    end
                    if (r_sel) n_tb_cnt = w_rel;
                    else       n_ta_cnt = w_rel;
                    if (w_cr[iat_pkg::CR_ONESHOT]) begin
                        if (r_sel) n_crb[iat_pkg::CR_START] = 1'b0;
                        else       n_cra[iat_pkg::CR_START] = 1'b0;
                        n_left = 8'd0;
                    end
                end else begin
                    n_state = iat_pkg::S_TMR_DEC;
                end
            end
            iat_pkg::S_TMR_DEC: begin
                if (r_sel) n_tb_cnt = w_rsp.sum;
                else       n_ta_cnt = w_rsp.sum;
                n_left  = 8'd0;
                n_state = iat_pkg::S_TMR_CMP;
            end
            iat_pkg::S_DONE: begin
                o_s_axis_tready = 1'b0;
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_rd;
                    n_m_user  = r_pulse;
                    n_state   = iat_pkg::S_IDLE;
                end
            end
            default: n_state = iat_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iat_pkg::S_IDLE;
            r_m_valid <= 1'b0;
            r_pra <= '0; r_prb <= '0; r_ddra <= '0; r_ddrb <= '0;
            r_ta_rel <= '0; r_tb_rel <= '0; r_ta_cnt <= '0; r_tb_cnt <= '0;
            r_cra <= '0; r_crb <= '0; r_tod <= '0; r_tod_hold <= '0;
            r_hold_vld <= 1'b0; r_presc <= '0; r_sdr <= 8'hFF;
            r_flags <= '0; r_ien <= '0;
        end else begin
            r_state <= n_state;
            r_m_valid <= n_m_valid;
            r_pra <= n_pra; r_prb <= n_prb; r_ddra <= n_ddra; r_ddrb <= n_ddrb;
            r_ta_rel <= n_ta_rel; r_tb_rel <= n_tb_rel;
            r_ta_cnt <= n_ta_cnt; r_tb_cnt <= n_tb_cnt;
            r_cra <= n_cra; r_crb <= n_crb; r_tod <= n_tod; r_tod_hold <= n_tod_hold;
            r_hold_vld <= n_hold_vld; r_presc <= n_presc; r_sdr <= n_sdr;
            r_flags <= n_flags; r_ien <= n_ien;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_addr <= n_addr; r_wdata <= n_wdata; r_clocks <= n_clocks;
        r_pa <= n_pa; r_pb <= n_pb;
        r_acc <= n_acc; r_left <= n_left; r_sel <= n_sel; r_rd <= n_rd;
        r_pulse <= n_pulse; r_m_data <= n_m_data; r_m_user <= n_m_user;
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_state == iat_pkg::S_EXEC))
        else $error("accepted transaction did not start execution");

    a_dec_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iat_pkg::S_TMR_DEC) |=> (r_left == 8'd0))
        else $error("timer remainder pass left clocks behind");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (r_state == iat_pkg::S_IDLE))
        else $error("input ready while an item is in progress");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iat_pkg::S_DONE && (!r_m_valid || i_m_axis_tready)) |=> o_m_axis_tvalid)
        else $error("finished item did not reach the output register");

endmodule

// File: design/iat_alu.sv
module iat_alu (
    input  iat_pkg::t_alu_req i_req,
    output iat_pkg::t_alu_rsp o_rsp
);
    logic [16:0] w_full;

    // With sub set, carry high means a >= b.
    assign w_full = {1'b0, i_req.a} + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                    + {16'd0, i_req.sub};
    assign o_rsp.sum   = w_full[15:0];
    assign o_rsp.carry = w_full[16];
endmodule
